### hdl/utoa_pkg.sv
// ----------------------------------------------------------------------------
// utoa_pkg
// Shared types, constants and helpers for the unsigned to ASCII radix core.
// ----------------------------------------------------------------------------
package utoa_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int CHUNK_W         = 8;
    localparam int RADIX_W         = 5;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0]  CHAR_NUL     = 7'h00;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE    = 7'h39;
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_F = 7'h66;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_F = 7'h46;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 4'd10;

    typedef struct packed {
        logic [63:0]        value;
        logic [RADIX_W-1:0] radix;
        logic               upper_case;
    } in_t;

    typedef struct packed {
        logic [CHAR_W-1:0] digit_char;
        logic              last;
        logic              bad_radix;
    } out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_READ,
        ST_EMIT,
        ST_BAD
    } state_t;

    function automatic logic [CHAR_W-1:0] ascii_digit(
        input logic [DIGIT_W-1:0] d,
        input logic               upper
    );
        logic [CHAR_W-1:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (d < DIGIT_TEN) begin
            return CHAR_ZERO + CHAR_W'(d);
        end else begin
            return base + CHAR_W'(d - DIGIT_TEN);
        end
    endfunction

endpackage

### hdl/utoa_div.sv
// ----------------------------------------------------------------------------
// utoa_div
// Iterative long division by a small radix, one byte of dividend per cycle.
// ----------------------------------------------------------------------------
module utoa_div #(
    parameter int VALUE_WIDTH = utoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            start,
    input  logic [VALUE_WIDTH-1:0]          dividend,
    input  logic [utoa_pkg::RADIX_W-1:0]    radix,
    output utoa_pkg::div_stat_t             stat,
    output logic [VALUE_WIDTH-1:0]          quotient,
    output logic [utoa_pkg::DIGIT_W-1:0]    remainder
);

    localparam int CW     = utoa_pkg::CHUNK_W;
    localparam int RW     = utoa_pkg::RADIX_W;
    localparam int CHUNKS = (VALUE_WIDTH + CW - 1) / CW;
    localparam int PAD_W  = CHUNKS * CW;
    localparam int CCW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

    logic [PAD_W-1:0]                  work_reg, work_next;
    logic [utoa_pkg::DIGIT_W-1:0]      rem_reg, rem_next;
    logic [CCW-1:0]                    cnt_reg, cnt_next;
    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [CW-1:0]                     q_chunk;
    logic [PAD_W+CW-1:0]               shifted;

    // restoring division over one byte of the dividend
    always_comb begin
        logic [RW-1:0] t;
        logic [CW-1:0] top;
        top = work_reg[PAD_W-1 -: CW];
        t   = RW'(rem_reg);
        for (int i = CW - 1; i >= 0; i--) begin
            t = {t[RW-2:0], top[i]};
            if (t >= radix) begin
                t = t - radix;
                q_chunk[i] = 1'b1;
            end else begin
                q_chunk[i] = 1'b0;
            end
        end
        rem_next = t[utoa_pkg::DIGIT_W-1:0];
    end

    assign shifted = {work_reg, q_chunk};

    always_comb begin
        work_next = work_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            work_next = PAD_W'(dividend);
            cnt_next  = CCW'(CHUNKS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            work_next = shifted[PAD_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        if (start) begin
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = work_reg[VALUE_WIDTH-1:0];
    assign remainder = rem_reg;

endmodule

### hdl/unsigned_to_ascii_radix_core.sv
// ----------------------------------------------------------------------------
// unsigned_to_ascii_radix_core
// Converts an unsigned value to ASCII digits in radix 2 to 16, most
// significant digit first, one character per output transfer.
// ----------------------------------------------------------------------------
// One input transfer is taken at a time. Each digit costs one pass of the
// shared byte-serial divider plus the START and WAIT sequencing states, and
// the digits are kept in a VALUE_WIDTH deep digit store; they are read back
// in reverse through the READ and EMIT states. A bad radix gives a single
// transfer. A finished character waits in the output register while the
// core moves on.
module unsigned_to_ascii_radix_core #(
    parameter int VALUE_WIDTH = utoa_pkg::VALUE_WIDTH_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  utoa_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output utoa_pkg::out_t m_data
);

    localparam int AW = $clog2(VALUE_WIDTH);
    localparam int NW = $clog2(VALUE_WIDTH + 1);

    utoa_pkg::state_t                  state_reg, state_next;
    logic [VALUE_WIDTH-1:0]            val_reg, val_next;
    logic [utoa_pkg::RADIX_W-1:0]      radix_reg, radix_next;
    logic                              upper_reg, upper_next;
    logic [NW-1:0]                     cnt_reg, cnt_next;
    logic [AW-1:0]                     rd_ptr_reg, rd_ptr_next;
    utoa_pkg::out_t                    out_reg, out_next;
    logic                              m_valid_reg, m_valid_next;
    logic [utoa_pkg::DIGIT_W-1:0]      rdata_reg;
    logic [utoa_pkg::DIGIT_W-1:0]      mem [VALUE_WIDTH];

    logic                              div_start;
    utoa_pkg::div_stat_t               div_stat;
    logic [VALUE_WIDTH-1:0]            div_quot;
    logic [utoa_pkg::DIGIT_W-1:0]      div_rem;
    logic                              mem_we;
    logic                              out_load;
    logic                              out_free;
    logic                              radix_bad;

    utoa_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (val_reg),
        .radix     (radix_reg),
        .stat      (div_stat),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign radix_bad = (s_data.radix < utoa_pkg::RADIX_MIN) ||
                       (s_data.radix > utoa_pkg::RADIX_MAX);

    always_comb begin
        state_next   = state_reg;
        val_next     = val_reg;
        radix_next   = radix_reg;
        upper_next   = upper_reg;
        cnt_next     = cnt_reg;
        rd_ptr_next  = rd_ptr_reg;
        out_next     = out_reg;
        s_ready      = 1'b0;
        div_start    = 1'b0;
        mem_we       = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            utoa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    val_next   = s_data.value[VALUE_WIDTH-1:0];
                    radix_next = s_data.radix;
                    upper_next = s_data.upper_case;
                    cnt_next   = '0;
                    state_next = radix_bad ? utoa_pkg::ST_BAD : utoa_pkg::ST_START;
                end
            end
            utoa_pkg::ST_START: begin
                div_start  = 1'b1;
                state_next = utoa_pkg::ST_WAIT;
            end
            utoa_pkg::ST_WAIT: begin
                if (div_stat.done) begin
                    mem_we   = 1'b1;
                    val_next = div_quot;
                    cnt_next = cnt_reg + 1'b1;
                    if (div_quot == '0) begin
                        rd_ptr_next = cnt_reg[AW-1:0];
                        state_next  = utoa_pkg::ST_READ;
                    end else begin
                        state_next  = utoa_pkg::ST_START;
                    end
                end
            end
            utoa_pkg::ST_READ: begin
                state_next = utoa_pkg::ST_EMIT;
            end
            utoa_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_next.digit_char = utoa_pkg::ascii_digit(rdata_reg, upper_reg);
                    out_next.last       = (rd_ptr_reg == '0);
                    out_next.bad_radix  = 1'b0;
                    if (rd_ptr_reg == '0) begin
                        state_next = utoa_pkg::ST_IDLE;
                    end else begin
                        rd_ptr_next = rd_ptr_reg - 1'b1;
                        state_next  = utoa_pkg::ST_READ;
                    end
                end
            end
            utoa_pkg::ST_BAD: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_next.digit_char = utoa_pkg::CHAR_NUL;
                    out_next.last       = 1'b1;
                    out_next.bad_radix  = 1'b1;
                    state_next          = utoa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = utoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= utoa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            rd_ptr_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            rd_ptr_reg  <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg   <= val_next;
        radix_reg <= radix_next;
        upper_reg <= upper_next;
        out_reg   <= out_next;
    end

    // digit store, least significant digit at the lowest address
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cnt_reg[AW-1:0]] <= div_rem;
        end
        rdata_reg <= mem[rd_ptr_reg];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_bad_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_radix |->
            m_data.last && (m_data.digit_char == utoa_pkg::CHAR_NUL))
        else $error("bad radix transfer not a lone null character");

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (cnt_reg < NW'(VALUE_WIDTH)))
        else $error("digit store overrun");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten before transfer");

    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.bad_radix |->
            ((m_data.digit_char >= utoa_pkg::CHAR_ZERO) &&
             (m_data.digit_char <= utoa_pkg::CHAR_NINE)) ||
            ((m_data.digit_char >= utoa_pkg::CHAR_LOWER_A) &&
             (m_data.digit_char <= utoa_pkg::CHAR_LOWER_F)) ||
            ((m_data.digit_char >= utoa_pkg::CHAR_UPPER_A) &&
             (m_data.digit_char <= utoa_pkg::CHAR_UPPER_F)))
        else $error("digit character out of range");

endmodule
